// ===== sv/while_language_tokenizer_assert.svh =====
// Assertion helpers for the tokenizer; clock and reset are the top-level names.
`ifndef WHILE_LANGUAGE_TOKENIZER_ASSERT_SVH
`define WHILE_LANGUAGE_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define WLT_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer same-cycle check failed");

// Next-cycle implication.
`define WLT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer next-cycle check failed");

`endif

// ===== sv/wlt_pkg.sv =====
`default_nettype none

package wlt_pkg;

   // Width of the running byte offset.
   localparam int PositionBits = 16;
   localparam int LenBits      = 16;
   localparam int LongIdent    = 255;
   localparam int MaxTokens    = 3;
   localparam int FifoDepth    = 8;
   localparam int PtrBits      = $clog2(FifoDepth);
   localparam int FillBits     = $clog2(FifoDepth + 1);

   typedef logic [PositionBits-1:0] pos_type;

   typedef enum logic [4:0] {
      KIND_END    = 5'd0,
      KIND_IDENT  = 5'd1,
      KIND_INT    = 5'd2,
      KIND_WHILE  = 5'd3,
      KIND_IF     = 5'd4,
      KIND_ELSE   = 5'd5,
      KIND_TRUE   = 5'd6,
      KIND_FALSE  = 5'd7,
      KIND_ASSIGN = 5'd8,
      KIND_EQ     = 5'd9,
      KIND_NE     = 5'd10,
      KIND_LT     = 5'd11,
      KIND_LE     = 5'd12,
      KIND_GT     = 5'd13,
      KIND_GE     = 5'd14,
      KIND_PLUS   = 5'd15,
      KIND_MINUS  = 5'd16,
      KIND_STAR   = 5'd17,
      KIND_SLASH  = 5'd18,
      KIND_LPAREN = 5'd19,
      KIND_RPAREN = 5'd20,
      KIND_LBRACE = 5'd21,
      KIND_RBRACE = 5'd22,
      KIND_SEMI   = 5'd23,
      KIND_ERROR  = 5'd24
   } token_kind_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       has_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [4:0]         token_kind;
      logic [15:0]        token_start;
      logic [LenBits-1:0] token_length;
      logic               last_of_run;
   } rsp_type;

   // Tokens produced by one input transaction, in order.
   typedef struct packed {
      rsp_type [MaxTokens-1:0] token;
      logic    [1:0]           count;
   } bundle_type;

   typedef struct packed {
      logic [FillBits-1:0] fill;
   } fifo_status_type;

endpackage

`default_nettype wire

// ===== sv/while_language_tokenizer.sv =====
// Streaming tokenizer for the "while" language. Each req transaction carries one
// source byte (or none, with has_char low) and may mark the end of the text; the
// scanner handles the byte combinationally and pushes the zero to three tokens it
// completes into an eight-entry token queue, and rsp presents one token per cycle
// from that queue while it is not empty and rsp_ready is high. req_ready stays high
// while the queue has room for three tokens, so a byte is taken every cycle as long
// as tokens drain at least as fast as they are made; sustained throughput is one
// token per cycle at the rsp port while rsp_ready stays high. An end token (start
// just past the last byte) follows every is_last transaction, after which offsets
// restart at zero. Reset clears the scanner mode, offsets and queue pointers.
`default_nettype none

module while_language_tokenizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire wlt_pkg::req_type  req,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wlt_pkg::rsp_type       rsp
);

   `include "while_language_tokenizer_assert.svh"

   wlt_pkg::bundle_type      bundle;
   wlt_pkg::fifo_status_type fifo_status;
   logic                     req_accept;
   logic                     rsp_accept;

   // Handshakes.
   assign req_ready  = fifo_status.fill <=
                       wlt_pkg::FillBits'(wlt_pkg::FifoDepth - wlt_pkg::MaxTokens);
   assign req_accept = req_valid & req_ready;
   assign rsp_valid  = fifo_status.fill != '0;
   assign rsp_accept = rsp_valid & rsp_ready;

   wlt_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .accept (req_accept),
      .bundle (bundle)
   );

   wlt_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (bundle),
      .push_en (req_accept),
      .pop     (rsp_accept),
      .head    (rsp),
      .status  (fifo_status)
   );

   `WLT_ASSERT_IMPLY(a_fill_bound, 1'b1, fifo_status.fill <= wlt_pkg::FillBits'(wlt_pkg::FifoDepth))
   `WLT_ASSERT_NEXT(a_end_queued, req_accept && req.is_last, rsp_valid)
   `WLT_ASSERT_NEXT(a_drain_empty, rsp_accept && fifo_status.fill == 1 && !req_accept, !rsp_valid)

endmodule

`default_nettype wire

// ===== sv/wlt_scan.sv =====
`default_nettype none

module wlt_scan (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wlt_pkg::req_type   req,
   input  wire logic               accept,
   output wlt_pkg::bundle_type     bundle
);

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_IDENT = 3'd1,
      MODE_INT   = 3'd2,
      MODE_EQ    = 3'd3,
      MODE_BANG  = 3'd4,
      MODE_LT    = 3'd5,
      MODE_GT    = 3'd6
   } mode_type;

   mode_type                       mode_ff, mode_in;
   wlt_pkg::pos_type               pos_ff, pos_in;
   wlt_pkg::pos_type               pstart_ff, pstart_in;
   logic [wlt_pkg::LenBits-1:0]    plen_ff, plen_in;
   logic [4:0][7:0]                prefix_ff, prefix_in;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   // Build one token with the start offset clipped to 16 bits.
   function automatic wlt_pkg::rsp_type make_tok(wlt_pkg::token_kind_type kind,
                                                 wlt_pkg::pos_type start,
                                                 logic [wlt_pkg::LenBits-1:0] len);
      wlt_pkg::rsp_type t;
      logic [32:0]      wide;
      wide          = 33'(start);
      t.token_kind  = kind;
      t.token_start = (wide > 33'd65535) ? 16'hFFFF : wide[15:0];
      t.token_length = len;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   // Identifier classification: long names are errors, then keywords.
   function automatic wlt_pkg::token_kind_type ident_kind(logic [wlt_pkg::LenBits-1:0] len,
                                                          logic [4:0][7:0] pf);
      wlt_pkg::token_kind_type k;
      k = wlt_pkg::KIND_IDENT;
      if (len >= wlt_pkg::LenBits'(wlt_pkg::LongIdent)) begin
         k = wlt_pkg::KIND_ERROR;
      end else if (len == 16'd5 && pf[0] == "w" && pf[1] == "h" && pf[2] == "i" &&
                   pf[3] == "l" && pf[4] == "e") begin
         k = wlt_pkg::KIND_WHILE;
      end else if (len == 16'd2 && pf[0] == "i" && pf[1] == "f") begin
         k = wlt_pkg::KIND_IF;
      end else if (len == 16'd4 && pf[0] == "e" && pf[1] == "l" && pf[2] == "s" &&
                   pf[3] == "e") begin
         k = wlt_pkg::KIND_ELSE;
      end else if (len == 16'd4 && pf[0] == "t" && pf[1] == "r" && pf[2] == "u" &&
                   pf[3] == "e") begin
         k = wlt_pkg::KIND_TRUE;
      end else if (len == 16'd5 && pf[0] == "f" && pf[1] == "a" && pf[2] == "l" &&
                   pf[3] == "s" && pf[4] == "e") begin
         k = wlt_pkg::KIND_FALSE;
      end
      return k;
   endfunction

   // Token for whatever is pending in the given mode (idle gives an unused value).
   function automatic wlt_pkg::rsp_type flush_tok(mode_type m, wlt_pkg::pos_type ps,
                                                  logic [wlt_pkg::LenBits-1:0] pl,
                                                  logic [4:0][7:0] pf);
      wlt_pkg::rsp_type t;
      case (m)
         MODE_IDENT: t = make_tok(ident_kind(pl, pf), ps, pl);
         MODE_INT:   t = make_tok(wlt_pkg::KIND_INT, ps, pl);
         MODE_EQ:    t = make_tok(wlt_pkg::KIND_ASSIGN, ps, 16'd1);
         MODE_BANG:  t = make_tok(wlt_pkg::KIND_ERROR, ps, 16'd1);
         MODE_LT:    t = make_tok(wlt_pkg::KIND_LT, ps, 16'd1);
         MODE_GT:    t = make_tok(wlt_pkg::KIND_GT, ps, 16'd1);
         default:    t = make_tok(wlt_pkg::KIND_END, ps, 16'd0);
      endcase
      return t;
   endfunction

   // One pass over the incoming byte: up to three tokens and the next state.
   always_comb begin
      wlt_pkg::rsp_type [wlt_pkg::MaxTokens-1:0] tok;
      logic [1:0]              cnt;
      logic                    used;
      logic                    single;
      wlt_pkg::token_kind_type kind;
      logic [7:0]              c;

      c      = req.char_in;
      tok    = '0;
      cnt    = 2'd0;
      used   = 1'b0;
      single = 1'b0;
      kind   = wlt_pkg::KIND_ERROR;

      case (mode_ff)
         MODE_IDENT, MODE_INT, MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: mode_in = mode_ff;
         default: mode_in = MODE_IDLE;
      endcase
      pos_in    = pos_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      prefix_in = prefix_ff;

      if (req.has_char) begin
         // Continue or close the pending token.
         case (mode_in)
            MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
               if (c == "=") begin
                  case (mode_in)
                     MODE_EQ:   kind = wlt_pkg::KIND_EQ;
                     MODE_BANG: kind = wlt_pkg::KIND_NE;
                     MODE_LT:   kind = wlt_pkg::KIND_LE;
                     default:   kind = wlt_pkg::KIND_GE;
                  endcase
                  tok[cnt] = make_tok(kind, pstart_in, 16'd2);
                  cnt      = cnt + 2'd1;
                  mode_in  = MODE_IDLE;
                  used     = 1'b1;
               end else begin
                  tok[cnt] = flush_tok(mode_in, pstart_in, plen_in, prefix_in);
                  cnt      = cnt + 2'd1;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_IDENT, MODE_INT: begin
               if (is_digit(c) || (mode_in == MODE_IDENT && (is_alpha(c) || c == "_"))) begin
                  if (plen_in < 16'd5) prefix_in[plen_in[2:0]] = c;
                  if (plen_in != '1) plen_in = plen_in + 16'd1;
                  used = 1'b1;
               end else begin
                  tok[cnt] = flush_tok(mode_in, pstart_in, plen_in, prefix_in);
                  cnt      = cnt + 2'd1;
                  mode_in  = MODE_IDLE;
               end
            end
            default: ;
         endcase

         // Byte opens something new.
         if (!used && !is_space(c)) begin
            case (c)
               "(": begin kind = wlt_pkg::KIND_LPAREN; single = 1'b1; end
               ")": begin kind = wlt_pkg::KIND_RPAREN; single = 1'b1; end
               "{": begin kind = wlt_pkg::KIND_LBRACE; single = 1'b1; end
               "}": begin kind = wlt_pkg::KIND_RBRACE; single = 1'b1; end
               ";": begin kind = wlt_pkg::KIND_SEMI;   single = 1'b1; end
               "+": begin kind = wlt_pkg::KIND_PLUS;   single = 1'b1; end
               "-": begin kind = wlt_pkg::KIND_MINUS;  single = 1'b1; end
               "*": begin kind = wlt_pkg::KIND_STAR;   single = 1'b1; end
               "/": begin kind = wlt_pkg::KIND_SLASH;  single = 1'b1; end
               "=": mode_in = MODE_EQ;
               "!": mode_in = MODE_BANG;
               "<": mode_in = MODE_LT;
               ">": mode_in = MODE_GT;
               default: begin
                  if (is_digit(c)) begin
                     mode_in = MODE_INT;
                  end else if (is_alpha(c) || c == "_") begin
                     mode_in = MODE_IDENT;
                  end else begin
                     kind   = wlt_pkg::KIND_ERROR;
                     single = 1'b1;
                  end
               end
            endcase
            if (single) begin
               tok[cnt] = make_tok(kind, pos_in, 16'd1);
               cnt      = cnt + 2'd1;
            end else begin
               pstart_in    = pos_in;
               plen_in      = 16'd1;
               prefix_in[0] = c;
            end
         end

         if (pos_in != '1) pos_in = pos_in + wlt_pkg::PositionBits'(1);
      end

      // End of text: flush, then the end token; offsets restart.
      if (req.is_last) begin
         if (mode_in != MODE_IDLE) begin
            tok[cnt] = flush_tok(mode_in, pstart_in, plen_in, prefix_in);
            cnt      = cnt + 2'd1;
         end
         tok[cnt] = make_tok(wlt_pkg::KIND_END, pos_in, 16'd0);
         cnt      = cnt + 2'd1;
         mode_in  = MODE_IDLE;
         pos_in   = '0;
      end

      if (cnt != 2'd0) tok[cnt - 2'd1].last_of_run = 1'b1;

      bundle.token = tok;
      bundle.count = cnt;
   end

   // Scanner state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wlt_fifo.sv =====
`default_nettype none

module wlt_fifo (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire wlt_pkg::bundle_type      push,
   input  wire logic                     push_en,
   input  wire logic                     pop,
   output wlt_pkg::rsp_type              head,
   output wlt_pkg::fifo_status_type      status
);

   wlt_pkg::rsp_type                mem_ff [wlt_pkg::FifoDepth];
   wlt_pkg::rsp_type                head_ff;
   wlt_pkg::rsp_type                bypass_tok;
   logic                            bypass_hit;
   logic [wlt_pkg::PtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [wlt_pkg::PtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [wlt_pkg::FillBits-1:0]    fill_ff, fill_in;
   logic [1:0]                      push_count;

   assign push_count = push_en ? push.count : 2'd0;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + wlt_pkg::PtrBits'(push_count);
      rd_ptr_in = rd_ptr_ff + wlt_pkg::PtrBits'(pop);
      fill_in   = fill_ff + wlt_pkg::FillBits'(push_count) - wlt_pkg::FillBits'(pop);
   end

   // A token written this cycle into the next read slot bypasses the memory.
   always_comb begin
      bypass_hit = 1'b0;
      bypass_tok = push.token[0];
      for (int i = 0; i < wlt_pkg::MaxTokens; i++) begin
         if (2'(i) < push_count && wr_ptr_ff + wlt_pkg::PtrBits'(i) == rd_ptr_in) begin
            bypass_hit = 1'b1;
            bypass_tok = push.token[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Up to three consecutive slots written per transaction.
   always_ff @(posedge clock) begin
      for (int i = 0; i < wlt_pkg::MaxTokens; i++) begin
         if (2'(i) < push_count) begin
            mem_ff[wr_ptr_ff + wlt_pkg::PtrBits'(i)] <= push.token[i];
         end
      end
   end

   // Registered head: holds the entry at the read pointer.
   always_ff @(posedge clock) begin
      head_ff <= bypass_hit ? bypass_tok : mem_ff[rd_ptr_in];
   end

   assign head        = head_ff;
   assign status.fill = fill_ff;

endmodule

`default_nettype wire
